FILE: hw/rtl/ppseq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppseq_pkg
// Item types and operation codes of the pulse protocol sequencer.
// ----------------------------------------------------------------------------
package ppseq_pkg;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_START   = 2'd1;
  localparam logic [1:0] MODE_TRIGGER = 2'd2;
  localparam logic [1:0] MODE_STOP    = 2'd3;

  localparam logic [1:0] KIND_REPLICATE = 2'd0;
  localparam logic [1:0] KIND_DELAY     = 2'd1;
  localparam logic [1:0] KIND_WIDTH     = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  protocol_index;
    logic [2:0]  channel;
    logic [1:0]  word_kind;
    logic [31:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic        commit_valid;
    logic [2:0]  out_channel;
    logic [31:0] delay_value;
    logic [31:0] width_value;
    logic [3:0]  active_protocol;
    logic        running;
    logic        last;
  } out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ppseq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppseq_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppseq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                                      clk,
  input  wire                                      we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                          wdata,
  input  wire                                      re,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/pulse_protocol_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_protocol_sequencer
// Protocol table and trigger sequencer for delay/width pulse channels.
// ----------------------------------------------------------------------------
// One item is handled at a time. A replicate-count load goes from idle to
// S_STATUS; a delay or width load passes S_LOAD_WR first (read-modify-write
// of the 64-bit channel entry). Stop goes straight to S_STATUS, and a
// non-committing trigger passes S_TRIG first. A committing trigger passes
// S_TRIG and S_RELOAD, then S_CMT_OUT, set by the single read port of the
// channel RAM, which delivers one channel entry per cycle while the output
// does not stall. Start adds S_START_RD for the protocol 0 count read. The
// output register lets the next item be accepted while the last result waits.
module pulse_protocol_sequencer #(
  parameter int PROTOCOLS = 16,
  parameter int CHANNELS  = 6
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire [4:0]           cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ppseq_pkg::in_item_t in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output ppseq_pkg::out_item_t out_data
);

  import ppseq_pkg::*;

  localparam int PI_W  = (PROTOCOLS > 1) ? $clog2(PROTOCOLS) : 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CA_W  = (PROTOCOLS * CHANNELS > 1) ? $clog2(PROTOCOLS * CHANNELS) : 1;
  localparam int CNT_W = ($clog2(PROTOCOLS + 1) > 5) ? $clog2(PROTOCOLS + 1) : 5;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LOAD_WR  = 3'd1;
  localparam logic [2:0] S_START_RD = 3'd2;
  localparam logic [2:0] S_TRIG     = 3'd3;
  localparam logic [2:0] S_RELOAD   = 3'd4;
  localparam logic [2:0] S_CMT_OUT  = 3'd5;
  localparam logic [2:0] S_STATUS   = 3'd6;

  logic [2:0]      state;
  logic [4:0]      protocol_count;
  logic [31:0]     remaining;
  logic [PI_W-1:0] cur;
  logic            running;
  logic [CH_W-1:0] cmt_ch;
  in_item_t        item;
  logic [CA_W-1:0] ld_addr;

  logic            accept;
  logic            can_load;
  logic            out_load;
  logic            load_rep_ok;
  logic            load_chan_ok;
  logic [CNT_W-1:0] eff_count;
  logic [CNT_W-1:0] cur_inc;
  logic [PI_W-1:0] cur_next;
  logic [CH_W-1:0] cmt_ch_sel;
  logic            cmt_last;
  logic [CA_W-1:0] in_chan_addr;
  logic [CA_W-1:0] cmt_addr;

  logic            rep_we;
  logic            rep_re;
  logic [PI_W-1:0] rep_raddr;
  logic [31:0]     rep_rdata;
  logic            chan_we;
  logic [63:0]     chan_wdata;
  logic            chan_re;
  logic [CA_W-1:0] chan_raddr;
  logic [63:0]     chan_rdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);
  assign can_load = !out_valid || !out_stall;
  assign out_load = can_load && ((state == S_CMT_OUT) || (state == S_STATUS));

  assign load_rep_ok  = (CNT_W'(in_data.protocol_index) < CNT_W'(PROTOCOLS)) &&
                        (in_data.word_kind == KIND_REPLICATE);
  assign load_chan_ok = (CNT_W'(in_data.protocol_index) < CNT_W'(PROTOCOLS)) &&
                        (5'(in_data.channel) < 5'(CHANNELS)) &&
                        ((in_data.word_kind == KIND_DELAY) ||
                         (in_data.word_kind == KIND_WIDTH));

  always_comb begin
    eff_count = CNT_W'(protocol_count);
    if (protocol_count == 5'd0) begin
      eff_count = CNT_W'(1);
    end else if (CNT_W'(protocol_count) > CNT_W'(PROTOCOLS)) begin
      eff_count = CNT_W'(PROTOCOLS);
    end
  end

  assign cur_inc  = CNT_W'(cur) + CNT_W'(1);
  assign cur_next = (cur_inc >= eff_count) ? '0 : PI_W'(cur_inc);

  assign cmt_last     = (cmt_ch == CH_W'(CHANNELS - 1));
  assign cmt_ch_sel   = (state == S_CMT_OUT) ? CH_W'(cmt_ch + 1'b1) : cmt_ch;
  assign in_chan_addr = CA_W'(CA_W'(in_data.protocol_index) * CA_W'(CHANNELS) +
                              CA_W'(in_data.channel));
  assign cmt_addr     = CA_W'(CA_W'(cur) * CA_W'(CHANNELS) + CA_W'(cmt_ch_sel));

  assign rep_we    = accept && (in_data.mode == MODE_LOAD) && load_rep_ok;
  assign rep_re    = (accept && (in_data.mode == MODE_START)) ||
                     ((state == S_TRIG) && (remaining == 32'd1));
  assign rep_raddr = (state == S_TRIG) ? cur_next : '0;

  assign chan_we    = (state == S_LOAD_WR);
  assign chan_wdata = (item.word_kind == KIND_DELAY) ?
                      {item.load_value, chan_rdata[31:0]} :
                      {chan_rdata[63:32], item.load_value};
  assign chan_re    = (accept && (in_data.mode == MODE_LOAD) && load_chan_ok) ||
                      (state == S_RELOAD) ||
                      ((state == S_CMT_OUT) && can_load && !cmt_last);
  assign chan_raddr = (state == S_IDLE) ? in_chan_addr : cmt_addr;

  ppseq_ram #(
    .WIDTH(32),
    .DEPTH(PROTOCOLS)
  ) u_rep_ram (
    .clk  (clk),
    .we   (rep_we),
    .waddr(PI_W'(in_data.protocol_index)),
    .wdata(in_data.load_value),
    .re   (rep_re),
    .raddr(rep_raddr),
    .rdata(rep_rdata)
  );

  ppseq_ram #(
    .WIDTH(64),
    .DEPTH(PROTOCOLS * CHANNELS)
  ) u_chan_ram (
    .clk  (clk),
    .we   (chan_we),
    .waddr(ld_addr),
    .wdata(chan_wdata),
    .re   (chan_re),
    .raddr(chan_raddr),
    .rdata(chan_rdata)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item    <= in_data;
      ld_addr <= in_chan_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      protocol_count <= 5'd1;
      remaining      <= '1;
      cur            <= '0;
      running        <= 1'b0;
      cmt_ch         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        protocol_count <= cfg_data;
      end
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.mode)
              MODE_LOAD: begin
                state <= load_chan_ok ? S_LOAD_WR : S_STATUS;
              end
              MODE_START: begin
                state <= S_START_RD;
              end
              MODE_TRIGGER: begin
                state <= S_TRIG;
              end
              default: begin
                running <= 1'b0;
                state   <= S_STATUS;
              end
            endcase
          end
        end
        S_LOAD_WR: begin
          state <= S_STATUS;
        end
        S_START_RD: begin
          remaining <= rep_rdata;
          cur       <= '0;
          running   <= 1'b1;
          state     <= S_TRIG;
        end
        S_TRIG: begin
          if (remaining == 32'd0) begin
            state <= S_STATUS;
          end else if (remaining != 32'd1) begin
            remaining <= remaining - 32'd1;
            state     <= S_STATUS;
          end else begin
            cur    <= cur_next;
            cmt_ch <= '0;
            state  <= S_RELOAD;
          end
        end
        S_RELOAD: begin
          remaining <= rep_rdata;
          state     <= S_CMT_OUT;
        end
        S_CMT_OUT: begin
          if (can_load) begin
            out_valid                <= 1'b1;
            out_data.commit_valid    <= 1'b1;
            out_data.out_channel     <= 3'(cmt_ch);
            out_data.delay_value     <= chan_rdata[63:32];
            out_data.width_value     <= chan_rdata[31:0];
            out_data.active_protocol <= 4'(cur);
            out_data.running         <= running;
            out_data.last            <= cmt_last;
            if (cmt_last) begin
              state <= S_IDLE;
            end else begin
              cmt_ch <= CH_W'(cmt_ch + 1'b1);
            end
          end
        end
        S_STATUS: begin
          if (can_load) begin
            out_valid                <= 1'b1;
            out_data.commit_valid    <= 1'b0;
            out_data.out_channel     <= 3'd0;
            out_data.delay_value     <= 32'd0;
            out_data.width_value     <= 32'd0;
            out_data.active_protocol <= 4'(cur);
            out_data.running         <= running;
            out_data.last            <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(cur) < CNT_W'(PROTOCOLS))
    else $error("protocol index beyond table");

  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.commit_valid) |->
      (out_data.last && (out_data.delay_value == 32'd0) && (out_data.out_channel == 3'd0)))
    else $error("malformed status result");

  a_last_channel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.commit_valid && out_data.last) |->
      (out_data.out_channel == 3'(CHANNELS - 1)))
    else $error("commit burst ended on wrong channel");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.mode == MODE_STOP)) |=> !running)
    else $error("stop did not clear running");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pulse protocol sequencer. A directed table
// covers table loads, start, trigger and stop corner cases. Random protocol
// traffic follows under several protocol counts and stall patterns. Every
// output transfer is compared field by field with a sequencer predictor.
// ----------------------------------------------------------------------------
module tb;
  import ppseq_pkg::*;

  localparam int PROTOCOLS     = 16;
  localparam int CHANNELS      = 6;
  localparam int SETTLE_CYCLES = CHANNELS + 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 6;
  localparam int REPORT_LIMIT  = 200;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t status;
  } vector_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;

  logic [31:0] replicate_tab [PROTOCOLS];
  logic [31:0] delay_tab [PROTOCOLS * CHANNELS];
  logic [31:0] width_tab [PROTOCOLS * CHANNELS];
  bit          replicate_set [PROTOCOLS];
  bit          delay_set [PROTOCOLS * CHANNELS];
  bit          width_set [PROTOCOLS * CHANNELS];
  logic [31:0] remaining = '1;
  logic [3:0]  protocol_now = '0;
  logic        running_now = 1'b0;
  logic [4:0]  count_reg = 5'd1;

  out_item_t   expected_results [$];
  out_item_t   step_results [CHANNELS];
  vector_t     directed [$];
  out_item_t   want;
  int          errors = 0;
  int unsigned cycles = 0;
  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;

  logic [4:0]  phase_cfg [RANDOM_PHASES] = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd0};
  int unsigned phase_send [RANDOM_PHASES] = '{0, 52, 0, 7, 0, 0, 52};
  int unsigned phase_recv [RANDOM_PHASES] = '{0, 0, 52, 7, 0, 52, 0};

  pulse_protocol_sequencer #(
    .PROTOCOLS(PROTOCOLS),
    .CHANNELS (CHANNELS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_count();
    if (count_reg == 0) return 1;
    if (count_reg > PROTOCOLS) return PROTOCOLS;
    return int'(count_reg);
  endfunction

  function automatic logic [3:0] wrap_protocol(input logic [3:0] p);
    return (int'(p) + 1 >= active_count()) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic bit count_down();
    if (remaining == 0) return 1'b0;
    remaining = remaining - 32'd1;
    if (remaining != 0) return 1'b0;
    protocol_now = wrap_protocol(protocol_now);
    remaining = replicate_tab[protocol_now];
    return 1'b1;
  endfunction

  function automatic int step_sequencer(input in_item_t it);
    bit commit;
    int a;
    int c;
    commit = 1'b0;
    a = int'(it.protocol_index) * CHANNELS + int'(it.channel);
    case (it.mode)
      MODE_LOAD: begin
        if (it.word_kind == KIND_REPLICATE) begin
          replicate_tab[it.protocol_index] = it.load_value;
          replicate_set[it.protocol_index] = 1'b1;
        end else if (it.word_kind != KIND_NONE && it.channel < CHANNELS) begin
          if (it.word_kind == KIND_DELAY) begin
            delay_tab[a] = it.load_value;
            delay_set[a] = 1'b1;
          end else begin
            width_tab[a] = it.load_value;
            width_set[a] = 1'b1;
          end
        end
      end
      MODE_START: begin
        protocol_now = '0;
        remaining = replicate_tab[0];
        commit = count_down();
        running_now = 1'b1;
      end
      MODE_TRIGGER: begin
        commit = count_down();
      end
      default: begin
        running_now = 1'b0;
      end
    endcase
    if (!commit) begin
      step_results[0] = {1'b0, 3'd0, 32'd0, 32'd0, protocol_now, running_now, 1'b1};
      return 1;
    end
    for (c = 0; c < CHANNELS; c++) begin
      a = int'(protocol_now) * CHANNELS + c;
      step_results[c] = {1'b1, 3'(c), delay_tab[a], width_tab[a], protocol_now, running_now,
                         c == CHANNELS - 1};
    end
    return CHANNELS;
  endfunction

  function automatic logic [31:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 32'd1;
    if (r < 85) return 32'($urandom_range(2, 4));
    if (r < 95) return 32'd0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_data();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'd0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.mode = (r < 25) ? MODE_LOAD : (r < 33) ? MODE_START : (r < 88) ? MODE_TRIGGER : MODE_STOP;
    if ($urandom_range(0, 99) < 70)
      it.protocol_index = 4'($urandom_range(0, active_count() - 1));
    else
      it.protocol_index = 4'($urandom_range(0, 15));
    it.channel = 3'($urandom_range(0, 7));
    r = $urandom_range(0, 99);
    it.word_kind = (r < 40) ? KIND_REPLICATE : (r < 65) ? KIND_DELAY :
                   (r < 90) ? KIND_WIDTH : KIND_NONE;
    it.load_value = (it.word_kind == KIND_REPLICATE) ? pick_count() : pick_data();
    return it;
  endfunction

  function automatic void add_row(input logic [1:0] mode, input logic [3:0] pidx,
                                  input logic [2:0] ch, input logic [1:0] kind,
                                  input logic [31:0] value, input bit typed,
                                  input logic [3:0] protocol, input logic run);
    vector_t v;
    v.item = {mode, pidx, ch, kind, value};
    v.typed = typed;
    v.status = {1'b0, 3'd0, 32'd0, 32'd0, protocol, run, 1'b1};
    directed.push_back(v);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (errors < REPORT_LIMIT)
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic push_item(input in_item_t it, input bit typed, input out_item_t status);
    int n;
    int k;
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = step_sequencer(it);
    if (typed) begin
      expected_results.push_back(status);
    end else begin
      for (k = 0; k < n; k++) expected_results.push_back(step_results[k]);
    end
  endtask

  task automatic fill_protocol(input logic [3:0] p);
    int c;
    if (!replicate_set[p])
      push_item({MODE_LOAD, p, 3'd0, KIND_REPLICATE, pick_count()}, 1'b0, '0);
    for (c = 0; c < CHANNELS; c++) begin
      if (!delay_set[int'(p) * CHANNELS + c])
        push_item({MODE_LOAD, p, 3'(c), KIND_DELAY, pick_data()}, 1'b0, '0);
      if (!width_set[int'(p) * CHANNELS + c])
        push_item({MODE_LOAD, p, 3'(c), KIND_WIDTH, pick_data()}, 1'b0, '0);
    end
  endtask

  // Write every table word that the next step would read and that is not yet set.
  task automatic prepare_reads(input logic [1:0] mode);
    if (mode == MODE_START) begin
      fill_protocol(4'd0);
      if (replicate_tab[0] == 32'd1) fill_protocol(wrap_protocol(4'd0));
    end else if (mode == MODE_TRIGGER && remaining == 32'd1) begin
      fill_protocol(wrap_protocol(protocol_now));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [4:0] value);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    count_reg = value;
  endtask

  always @(posedge clk) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (errors < REPORT_LIMIT)
          $display("%0t: transfer with nothing expected, actual %h", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("commit_valid", want.commit_valid, out_data.commit_valid);
        check_field("out_channel", want.out_channel, out_data.out_channel);
        check_field("delay_value", want.delay_value, out_data.delay_value);
        check_field("width_value", want.width_value, out_data.width_value);
        check_field("active_protocol", want.active_protocol, out_data.active_protocol);
        check_field("running", want.running, out_data.running);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    int i;
    int ph;
    add_row(MODE_TRIGGER, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_STOP, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_REPLICATE, 32'd1, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_DELAY, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_WIDTH, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd5, KIND_DELAY, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd5, KIND_WIDTH, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_NONE, 32'h1234_5678, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd6, KIND_DELAY, 32'hDEAD_BEEF, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd7, KIND_WIDTH, 32'hCAFE_F00D, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd15, 3'd7, KIND_REPLICATE, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd15, 3'd5, KIND_DELAY, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0);
    add_row(MODE_START, 4'd15, 3'd7, KIND_NONE, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);
    add_row(MODE_TRIGGER, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_STOP, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_TRIGGER, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b1, 4'd0, 1'b0);
    add_row(MODE_START, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_TRIGGER, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_REPLICATE, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b1);
    add_row(MODE_START, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_LOAD, 4'd0, 3'd0, KIND_REPLICATE, 32'd2, 1'b1, 4'd0, 1'b1);
    add_row(MODE_START, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    add_row(MODE_TRIGGER, 4'd0, 3'd0, KIND_REPLICATE, 32'd0, 1'b0, 4'd0, 1'b0);
    phase_cfg[RANDOM_PHASES - 1] = 5'($urandom_range(0, 31));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed.size(); i++) begin
      prepare_reads(directed[i].item.mode);
      push_item(directed[i].item, directed[i].typed, directed[i].status);
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      send_pct = phase_send[ph];
      recv_pct = phase_recv[ph];
      write_count(phase_cfg[ph]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        it = random_item();
        prepare_reads(it.mode);
        push_item(it, 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ppseq_pkg.sv
hw/rtl/ppseq_ram.sv
hw/rtl/pulse_protocol_sequencer.sv
sim/tb.sv
